FILE: rtl/pvc_pkg.sv
// Shared constants and transfer payload types for the PID velocity controller.
package pvc_pkg;

    // Default number of fractional bits for gains and internal terms.
    localparam int FRAC_BITS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int ERR_W   = 24;
    localparam int SPD_W   = 32;
    localparam int GAIN_W  = 32;
    localparam int SCALE_W = 32;
    localparam int MAG_W   = 32;
    localparam int DF_W    = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = CFG_IDX_W'(3);

    // Control law constants.
    localparam int P_CLAMP_OFFSET = 10000;
    localparam int I_CLAMP        = 200000;
    localparam int I_CLAMP_BITS   = 18;     // I_CLAMP is below 2**18.
    localparam int DEADBAND       = 10;
    localparam int DIV_BY         = 10;     // Derivative filter divisor.

    typedef struct packed {
        logic signed [ERR_W-1:0] pos_error;
        logic signed [SPD_W-1:0] present_speed;
    } pvc_in_t;

    typedef struct packed {
        logic             direction;
        logic [MAG_W-1:0] speed_magnitude;
    } pvc_out_t;

endpackage

FILE: rtl/pvc_serial_mul.sv
// Shift-add multiplier that consumes one multiplier bit per cycle, LSB first.
module pvc_serial_mul #(
    parameter int WA = 32,
    parameter int WB = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [WA-1:0] a,
    input  logic        [WB-1:0] b,
    output logic                 done,
    output logic     [WA+WB:0]   product
);

    localparam int CNT_W = $clog2(WB);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WA-1:0]    a_reg;
    logic [WA:0]      p_reg;
    logic [WB-1:0]    b_reg;

    logic             last;
    logic [WA+1:0]    a_ext;
    logic [WA+1:0]    addend;
    logic [WA+1:0]    sum;
    logic [WA:0]      p_next;
    logic [WB-1:0]    b_next;

    // The multiplier is two's complement, so its top bit carries negative weight.
    always_comb begin
        last  = (cnt_reg == CNT_W'(WB - 1));
        a_ext = {{2{a_reg[WA-1]}}, a_reg};
        if (!b_reg[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -a_ext;
        end else begin
            addend = a_ext;
        end
        sum    = {p_reg[WA], p_reg} + addend;
        p_next = sum[WA+1:1];
        b_next = {sum[0], b_reg[WB-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= '0;
            b_reg <= b;
        end else if (busy_reg) begin
            p_reg <= p_next;
            b_reg <= b_next;
        end
    end

    assign done    = done_reg;
    assign product = {p_reg, b_reg};

endmodule

FILE: rtl/pvc_div10.sv
// Radix-4 serial divider by ten: two dividend bits per cycle, MSB first.
module pvc_div10 #(
    parameter int NW = 60
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int STEPS = NW / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [5:0] D1 = 6'(pvc_pkg::DIV_BY);
    localparam logic [5:0] D2 = 6'(2 * pvc_pkg::DIV_BY);
    localparam logic [5:0] D3 = 6'(3 * pvc_pkg::DIV_BY);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [3:0]       rem_reg;
    logic [NW-1:0]    n_reg;

    logic             last;
    logic [5:0]       t;
    logic [5:0]       t_diff;
    logic [1:0]       q_dig;
    logic [3:0]       rem_next;
    logic [NW-1:0]    n_next;

    // The remainder stays below ten, so a partial value is below forty and
    // each quotient digit is found by three compares.
    always_comb begin
        last = (cnt_reg == CNT_W'(STEPS - 1));
        t    = {rem_reg, n_reg[NW-1 -: 2]};
        if (t >= D3) begin
            q_dig  = 2'd3;
            t_diff = t - D3;
        end else if (t >= D2) begin
            q_dig  = 2'd2;
            t_diff = t - D2;
        end else if (t >= D1) begin
            q_dig  = 2'd1;
            t_diff = t - D1;
        end else begin
            q_dig  = 2'd0;
            t_diff = t;
        end
        rem_next = t_diff[3:0];
        n_next   = {n_reg[NW-3:0], q_dig};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            n_reg   <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            n_reg   <= n_next;
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

FILE: rtl/pid_velocity_controller.sv
// Top level of the PID velocity controller: sequencer, control law state and ports.
//
// The controller takes one sample (position error and present speed) per input
// transfer and returns one result transfer with a motor direction and a
// saturated speed magnitude. It processes one sample at a time and accepts
// the next sample only once the last result has gone to the output register.
// Each sample passes through three serial units in turn: the gain multipliers
// take one error bit per cycle, the derivative filter divides by ten two bits
// per cycle, and the output scale multiplier takes one scale bit per cycle,
// together with the clamping, summing and handoff steps. A finished result
// waits in the output register while the next sample is already accepted
// and worked on. Gains and internal terms carry FRAC_BITS fractional bits.
// Configuration registers are written through the plain write port and
// must only be written while the block is idle.
module pid_velocity_controller #(
    parameter int FRAC_BITS = pvc_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [pvc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pvc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  pvc_pkg::pvc_in_t                 s_data,

    output logic                             m_valid,
    input  logic                             m_ready,
    output pvc_pkg::pvc_out_t                m_data
);

    // Widths of the internal terms.
    localparam int EW    = pvc_pkg::ERR_W;
    localparam int DEW   = EW + 1;                        // Error difference.
    localparam int GW    = pvc_pkg::GAIN_W;
    localparam int PW    = GW + 1 + DEW;                  // Gain products.
    localparam int SUMW  = PW + 1;                        // Clamp and filter sums.
    localparam int IW    = FRAC_BITS + pvc_pkg::I_CLAMP_BITS + 1;
    localparam int DF_W  = pvc_pkg::DF_W;
    localparam int DVN   = SUMW + (SUMW % 2);             // Divider width, even.
    localparam int DQW   = DVN + 1;
    localparam int UW    = PW + 2;                        // Sum of the three terms.
    localparam int SW    = pvc_pkg::SCALE_W;
    localparam int MAG_W = pvc_pkg::MAG_W;
    localparam int MA_W  = UW + 1;
    localparam int MB_W  = SW + 1;
    localparam int PRW   = MA_W + MB_W + 1;
    localparam int SHIFT = 2 * FRAC_BITS;

    localparam logic signed [SUMW-1:0] I_LIM   = SUMW'(pvc_pkg::I_CLAMP) << FRAC_BITS;
    localparam logic signed [IW-1:0]   I_LIM_I = IW'(I_LIM);
    localparam logic signed [DQW-1:0]  D_MAX   = (DQW'(1) << (DF_W - 1)) - DQW'(1);
    localparam logic signed [EW-1:0]   DB_HI   = EW'(pvc_pkg::DEADBAND);
    localparam logic signed [EW-1:0]   DB_LO   = -DB_HI;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // Configuration registers.
    logic signed [GW-1:0]   p_gain_reg;
    logic signed [GW-1:0]   i_gain_reg;
    logic signed [GW-1:0]   d_gain_reg;
    logic        [SW-1:0]   scale_reg;

    // Control law state.
    logic signed [IW-1:0]   integ_reg,    integ_next;
    logic                   latched_reg,  latched_next;
    logic signed [EW-1:0]   prev_err_reg, prev_err_next;
    logic signed [DF_W-1:0] df_reg,       df_next;

    // Sequencer and per-sample working registers.
    logic [2:0]               state_reg,  state_next;
    logic signed [EW-1:0]     e_reg,      e_next;
    logic signed [pvc_pkg::SPD_W-1:0] spd_reg, spd_next;
    logic signed [PW-1:0]     p_term_reg, p_term_next;
    logic                     dneg_reg,   dneg_next;
    logic                     upos_reg,   upos_next;
    logic                     m_valid_reg, m_valid_next;
    pvc_pkg::pvc_out_t        m_data_reg, m_data_next;

    // Serial unit connections.
    logic                     in_xfer;
    logic [DEW-1:0]           mul_b_e;
    logic [DEW-1:0]           mul_b_de;
    logic signed [PW-1:0]     prod_p;
    logic signed [PW-1:0]     prod_i;
    logic signed [PW-1:0]     prod_d;
    logic                     done_p, done_i, done_d;
    logic                     gain_done;
    logic                     div_start;
    logic                     div_done;
    logic [DVN-1:0]           div_dividend;
    logic [DVN-1:0]           div_q;
    logic                     scale_start;
    logic                     scale_done;
    logic [MA_W-1:0]          scale_a;
    logic [PRW-1:0]           prod_s;

    // Combinational working values.
    logic [pvc_pkg::SPD_W-1:0] spd_abs;
    logic [pvc_pkg::SPD_W-1:0] lim_base;
    logic signed [SUMW-1:0]    lim;
    logic signed [SUMW-1:0]    p_ext;
    logic signed [SUMW-1:0]    p_clamp;
    logic signed [SUMW-1:0]    integ_sum;
    logic signed [SUMW-1:0]    integ_clamp;
    logic                      in_band;
    logic signed [SUMW-1:0]    df9;
    logic signed [SUMW-1:0]    dsum;
    logic signed [DQW-1:0]     qz;
    logic signed [DQW-1:0]     qs;
    logic signed [DQW-1:0]     qc;
    logic signed [UW-1:0]      u;
    logic [UW-1:0]             umag;
    logic [PRW-1:0]            shifted;
    logic                      sat;
    logic [MAG_W-1:0]          mag_out;
    logic                      out_free;

    assign s_ready = (state_reg == S_IDLE);
    assign in_xfer = s_valid && s_ready;

    // The gain multipliers start straight from the input transfer, so the
    // error and the error difference feed them before they are registered.
    assign mul_b_e  = {s_data.pos_error[EW-1], s_data.pos_error};
    assign mul_b_de = {s_data.pos_error[EW-1], s_data.pos_error}
                    - {prev_err_reg[EW-1], prev_err_reg};

    pvc_serial_mul #(.WA(GW), .WB(DEW)) u_mul_p (
        .aclk(aclk), .aresetn(aresetn), .start(in_xfer),
        .a(p_gain_reg), .b(mul_b_e), .done(done_p), .product(prod_p)
    );

    pvc_serial_mul #(.WA(GW), .WB(DEW)) u_mul_i (
        .aclk(aclk), .aresetn(aresetn), .start(in_xfer),
        .a(i_gain_reg), .b(mul_b_e), .done(done_i), .product(prod_i)
    );

    pvc_serial_mul #(.WA(GW), .WB(DEW)) u_mul_d (
        .aclk(aclk), .aresetn(aresetn), .start(in_xfer),
        .a(d_gain_reg), .b(mul_b_de), .done(done_d), .product(prod_d)
    );

    assign gain_done = done_p && done_i && done_d;

    pvc_div10 #(.NW(DVN)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .done(div_done), .quotient(div_q)
    );

    pvc_serial_mul #(.WA(MA_W), .WB(MB_W)) u_mul_s (
        .aclk(aclk), .aresetn(aresetn), .start(scale_start),
        .a(scale_a), .b({1'b0, scale_reg}), .done(scale_done), .product(prod_s)
    );

    // Proportional clamp, integral update and derivative dividend. These are
    // evaluated when the gain products are ready.
    always_comb begin
        spd_abs  = spd_reg[pvc_pkg::SPD_W-1] ? (~spd_reg + 1'b1) : spd_reg;
        lim_base = spd_abs + pvc_pkg::SPD_W'(pvc_pkg::P_CLAMP_OFFSET);
        lim      = SUMW'(lim_base) << FRAC_BITS;
        p_ext    = SUMW'(prod_p);
        if (p_ext > lim) begin
            p_clamp = lim;
        end else if (p_ext < -lim) begin
            p_clamp = -lim;
        end else begin
            p_clamp = p_ext;
        end

        integ_sum = SUMW'(integ_reg) + SUMW'(prod_i);
        if (integ_sum > I_LIM) begin
            integ_clamp = I_LIM;
        end else if (integ_sum < -I_LIM) begin
            integ_clamp = -I_LIM;
        end else begin
            integ_clamp = integ_sum;
        end
        in_band = (e_reg > DB_LO) && (e_reg < DB_HI);

        df9          = (SUMW'(df_reg) <<< 3) + SUMW'(df_reg);
        dsum         = df9 + SUMW'(prod_d);
        div_dividend = DVN'(dsum[SUMW-1] ? -dsum : dsum);
    end

    // Filter quotient back to a signed value, clamped to the symmetric
    // 48-bit range.
    always_comb begin
        qz = $signed({1'b0, div_q});
        qs = dneg_reg ? -qz : qz;
        if (qs > D_MAX) begin
            qc = D_MAX;
        end else if (qs < -D_MAX) begin
            qc = -D_MAX;
        end else begin
            qc = qs;
        end
    end

    // Control sum and its magnitude for the output scale multiplier.
    always_comb begin
        u       = UW'(p_term_reg) + UW'(integ_reg) + UW'(df_reg);
        umag    = u[UW-1] ? -u : u;
        scale_a = {1'b0, umag};
    end

    // Drop the fractional bits of gain and scale and saturate to 32 bits.
    // Direction follows the sign of the sum but only for a nonzero drive.
    always_comb begin
        shifted  = prod_s >> SHIFT;
        sat      = |shifted[PRW-1:MAG_W];
        mag_out  = sat ? '1 : shifted[MAG_W-1:0];
        out_free = !m_valid_reg || m_ready;
    end

    assign div_start   = (state_reg == S_MUL) && gain_done;
    assign scale_start = (state_reg == S_SUM);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        e_next        = e_reg;
        spd_next      = spd_reg;
        prev_err_next = prev_err_reg;
        p_term_next   = p_term_reg;
        dneg_next     = dneg_reg;
        upos_next     = upos_reg;
        integ_next    = integ_reg;
        latched_next  = latched_reg;
        df_next       = df_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    e_next        = s_data.pos_error;
                    spd_next      = s_data.present_speed;
                    prev_err_next = s_data.pos_error;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                if (gain_done) begin
                    p_term_next = PW'(p_clamp);
                    dneg_next   = dsum[SUMW-1];
                    // The integral is cleared once on entering the deadband and
                    // re-armed when the error leaves it.
                    if (in_band && !latched_reg) begin
                        integ_next = '0;
                    end else begin
                        integ_next = IW'(integ_clamp);
                    end
                    latched_next = in_band;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    df_next    = DF_W'(qc);
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                upos_next  = !u[UW-1] && (u != '0);
                state_next = S_SCALE;
            end
            S_SCALE: begin
                if (scale_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_data_next.direction       = upos_reg && (mag_out != '0);
                    m_data_next.speed_magnitude = mag_out;
                    m_valid_next                = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            latched_reg  <= 1'b0;
            prev_err_reg <= '0;
            df_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            integ_reg    <= integ_next;
            latched_reg  <= latched_next;
            prev_err_reg <= prev_err_next;
            df_reg       <= df_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg      <= e_next;
        spd_reg    <= spd_next;
        p_term_reg <= p_term_next;
        dneg_reg   <= dneg_next;
        upos_reg   <= upos_next;
        m_data_reg <= m_data_next;
    end

    // Configuration writes. An index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg <= '0;
            i_gain_reg <= '0;
            d_gain_reg <= '0;
            scale_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pvc_pkg::REG_P_GAIN:       p_gain_reg <= cfg_wr_data;
                pvc_pkg::REG_I_GAIN:       i_gain_reg <= cfg_wr_data;
                pvc_pkg::REG_D_GAIN:       d_gain_reg <= cfg_wr_data;
                pvc_pkg::REG_OUTPUT_SCALE: scale_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // All three gain products are ready together after each input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> ##(DEW + 1) gain_done)
        else $error("gain multipliers did not finish on schedule");

    // The integral never leaves its clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg <= I_LIM_I) && (integ_reg >= -I_LIM_I))
        else $error("integral term outside its clamp");

    // The filtered derivative is clamped symmetrically.
    assert property (@(posedge aclk) disable iff (!aresetn)
        df_reg != {1'b1, {(DF_W - 1){1'b0}}})
        else $error("derivative term reached the most negative value");

    // A forward direction is only reported with a nonzero magnitude.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.direction && (m_data.speed_magnitude == '0)))
        else $error("direction set for zero drive");

endmodule
